// ----- src/rpss_pkg.sv -----
// rpss_pkg: shared widths, codes and constants of the reflow setpoint sequencer
// used by rpss_mul, rpss_div and reflow_profile_setpoint_sequencer
`default_nettype none
package rpss_pkg;

  // datapath widths
  localparam int unsigned AccW     = 58;  // signed product plus offset, and its magnitude
  localparam int unsigned DenW     = 24;  // divisor width
  localparam int unsigned CntW     = 6;   // step counter of the serial units
  localparam int unsigned MulSteps = 32;  // one multiplier bit per cycle
  localparam int unsigned DivSteps = AccW; // one quotient bit per cycle

  // sequencing constants
  localparam logic [11:0] MinStartQ2     = 12'd120;     // 30 degrees in quarter degrees
  localparam logic [31:0] UpdatePeriodMs = 32'd1000;
  localparam logic [23:0] MsQ14Den       = 24'd16384000; // 1000 ms times Q14 one
  localparam logic [23:0] Q14Den         = 24'd16384;
  localparam logic [9:0]  TempDone       = 10'd10;
  localparam logic [9:0]  CoolFloor      = 10'd50;
  localparam logic [9:0]  CoolLow        = 10'd20;
  localparam logic [11:0] CoolEndQ2      = 12'd200;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STG_IDLE    = 3'd0,
    STG_PREHEAT = 3'd1,
    STG_SOAK    = 3'd2,
    STG_RAMP    = 3'd3,
    STG_HOLD    = 3'd4,
    STG_COOL    = 3'd5,
    STG_DONE    = 3'd6
  } stage_e;

  // what to do with the quotient of the serial units
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SLOPE,
    OP_PRE,
    OP_SOAK,
    OP_RAMP,
    OP_COOL
  } op_e;

  typedef enum logic [2:0] {
    CFG_PREHEAT_TEMP = 3'd0,
    CFG_PREHEAT_SECS = 3'd1,
    CFG_SOAK_SECS    = 3'd2,
    CFG_SOAK_TEMP    = 3'd3,
    CFG_PEAK_TEMP    = 3'd4,
    CFG_RAMP_SECS    = 3'd5,
    CFG_HOLD_SECS    = 3'd6,
    CFG_COOL_RATE    = 3'd7
  } cfg_idx_e;

endpackage
`default_nettype wire

// ----- src/reflow_profile_setpoint_sequencer.sv -----
// Reflow setpoint sequencer: one result beat per command beat.
// A command without arithmetic loads its result beat directly; when a slope or
// target is computed, a 32-step serial multiplier runs first, then a 58-step serial divider.
// A new command is taken only while the sequencer is idle and no result beat is pending;
// the next command waits until the result beat is gone.
// Reset: asynchronous active low; registers take their default profile, stage idle.
`default_nettype none
module reflow_profile_setpoint_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i,
  // command beat
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [11:0] measured_temp_q2_i,
  input  wire logic [31:0] now_ms_i,
  // result beat
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [9:0]       target_temp_o,
  output logic [2:0]       stage_o,
  output logic             run_complete_o,
  output logic             stage_finished_o,
  output logic [31:0]      stage_elapsed_ms_o,
  output logic [31:0]      run_elapsed_ms_o
);

  localparam int unsigned AccW = rpss_pkg::AccW;
  localparam int unsigned DenW = rpss_pkg::DenW;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_DIV
  } seq_e;

  // profile registers
  logic [8:0] pt_q, se_q, pk_q;
  logic [9:0] prs_q, ss_q, rrs_q, rhs_q, crq_q;

  // run state
  seq_e              st_q, st_d;
  rpss_pkg::stage_e  stage_q, stage_d;
  rpss_pkg::op_e     op_q, op_d;
  logic [31:0]       sstart_q, sstart_d, rstart_q, rstart_d;
  logic [31:0]       pclk_q, pclk_d, last_q, last_d;
  logic              pvld_q, pvld_d;
  logic [11:0]       base_q, base_d;
  logic [9:0]        setp_q, setp_d, sl_q, sl_d;
  logic [23:0]       slope_q, slope_d;
  logic [DenW-1:0]   den_q, den_d;
  logic              rnd_q, rnd_d, neg_q, neg_d;

  // result register
  logic              ov_q, ov_d;
  logic [9:0]        o_tgt_q, o_tgt_d;
  rpss_pkg::stage_e  o_stage_q, o_stage_d;
  logic              o_done_q, o_done_d, o_fin_q, o_fin_d;
  logic [31:0]       o_sms_q, o_sms_d, o_rms_q, o_rms_d;

  // serial unit hookup
  logic              mul_go, mul_done, div_go, div_done;
  logic [31:0]       a_mag;
  logic              b_neg;
  logic [AccW-1:0]   c_val, b_ext, b_in, prod, prod_mag, div_num, quo;

  // decoded helpers
  logic              accept, due;
  rpss_pkg::cmd_e    cmd;
  logic [11:0]       meas;
  logic [31:0]       now;
  logic [31:0]       pclk_new;
  logic [11:0]       base_new;
  logic [12:0]       sum_start;
  logic [12:0]       diff_st;
  logic [9:0]        diff_sp, diff_rp;
  logic [10:0]       a_soak;
  logic [10:0]       a_soak_mag;
  logic [21:0]       base_k;
  logic [18:0]       se_k;
  logic [9:0]        sat_q, lim, cool_t;
  logic [10:0]       t_cool;
  logic [23:0]       slope_fin;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == SEQ_IDLE) && !ov_q;
  assign cmd        = rpss_pkg::cmd_e'(command_i);
  assign meas       = measured_temp_q2_i;
  assign now        = now_ms_i;
  assign due        = (now - last_q) >= rpss_pkg::UpdatePeriodMs;

  // start values
  assign base_new  = (meas < rpss_pkg::MinStartQ2) ? rpss_pkg::MinStartQ2 : meas;
  assign sum_start = {1'b0, base_new} + 13'd2;
  assign diff_st   = {2'b00, pt_q, 2'b00} - {1'b0, base_new};

  // slope numerators and ramp offsets, times 1000 as shifts
  assign diff_sp = {1'b0, se_q} - {1'b0, pt_q};
  assign diff_rp = {1'b0, pk_q} - {1'b0, se_q};
  assign base_k  = {base_q, 10'b0} - {6'b0, base_q, 4'b0} - {7'b0, base_q, 3'b0};
  assign se_k    = {se_q, 10'b0} - {6'b0, se_q, 4'b0} - {7'b0, se_q, 3'b0};

  // soak elapsed seconds, may go negative after a profile change
  assign a_soak     = {1'b0, ss_q} - {1'b0, sl_q};
  assign a_soak_mag = a_soak[10] ? (11'd0 - a_soak) : a_soak;

  assign pclk_new = pvld_q ? pclk_q : now;

  // multiplier operand b: slope with the sign of a folded in
  assign b_ext = {{(AccW-24){slope_q[23]}}, slope_q};
  assign b_in  = b_neg ? ('0 - b_ext) : b_ext;

  // divider numerator: magnitude plus half the divisor when rounding
  assign prod_mag = prod[AccW-1] ? ('0 - prod) : prod;
  assign div_num  = prod_mag + (rnd_q ? {{(AccW-DenW+1){1'b0}}, den_q[DenW-1:1]} : '0);

  // quotient post-processing
  assign sat_q  = (|quo[AccW-1:10]) ? 10'd1023 : quo[9:0];
  assign t_cool = {1'b0, base_q[11:2]} - {1'b0, quo[9:0]};
  assign cool_t = ((|quo[AccW-1:10]) || t_cool[10] || (t_cool[9:0] < rpss_pkg::CoolFloor))
                  ? rpss_pkg::CoolLow : t_cool[9:0];

  always_comb begin
    if (!neg_q) begin
      slope_fin = (|quo[AccW-1:23]) ? 24'h7FFFFF : quo[23:0];
    end else if ((|quo[AccW-1:24]) || (quo[23] && (|quo[22:0]))) begin
      slope_fin = 24'h800000;
    end else begin
      slope_fin = 24'd0 - quo[23:0];
    end
  end

  always_comb begin
    unique case (op_q)
      rpss_pkg::OP_PRE:  lim = {1'b0, pt_q};
      rpss_pkg::OP_SOAK: lim = {1'b0, se_q};
      default:           lim = {1'b0, pk_q};
    endcase
  end

  // command decode and sequencing
  always_comb begin
    st_d      = st_q;
    stage_d   = stage_q;
    op_d      = op_q;
    sstart_d  = sstart_q;
    rstart_d  = rstart_q;
    pclk_d    = pclk_q;
    pvld_d    = pvld_q;
    last_d    = last_q;
    base_d    = base_q;
    setp_d    = setp_q;
    sl_d      = sl_q;
    slope_d   = slope_q;
    den_d     = den_q;
    rnd_d     = rnd_q;
    neg_d     = neg_q;
    ov_d      = ov_q;
    o_tgt_d   = o_tgt_q;
    o_stage_d = o_stage_q;
    o_done_d  = o_done_q;
    o_fin_d   = o_fin_q;
    o_sms_d   = o_sms_q;
    o_rms_d   = o_rms_q;
    mul_go    = 1'b0;
    div_go    = 1'b0;
    a_mag     = '0;
    b_neg     = 1'b0;
    c_val     = '0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (st_q)
      SEQ_IDLE: begin
        if (accept) begin
          o_fin_d  = 1'b0;
          o_done_d = 1'b0;
          o_sms_d  = '0;
          o_rms_d  = '0;
          op_d     = rpss_pkg::OP_NONE;
          unique case (cmd)
            rpss_pkg::CMD_START: begin
              stage_d  = rpss_pkg::STG_PREHEAT;
              base_d   = base_new;
              setp_d   = sum_start[12] ? 10'd1023 : sum_start[11:2];
              sl_d     = '0;
              rstart_d = now;
              sstart_d = now;
              pclk_d   = '0;
              pvld_d   = 1'b0;
              last_d   = '0;
              if (prs_q == '0) begin
                slope_d = '0;
              end else begin
                op_d  = rpss_pkg::OP_SLOPE;
                c_val = {{(AccW-25){diff_st[12]}}, diff_st, 12'b0};
                den_d = {{(DenW-10){1'b0}}, prs_q};
                rnd_d = 1'b0;
              end
            end
            rpss_pkg::CMD_STOP: begin
              stage_d = rpss_pkg::STG_IDLE;
            end
            rpss_pkg::CMD_SAMPLE: begin
              unique case (stage_q)
                rpss_pkg::STG_PREHEAT: begin
                  if (meas >= {1'b0, pt_q, 2'b00}) begin
                    // preheat ends, soak begins
                    o_fin_d  = 1'b1;
                    o_sms_d  = now - sstart_q;
                    sstart_d = now;
                    pclk_d   = now;
                    pvld_d   = 1'b1;
                    last_d   = now;
                    if (ss_q == '0) begin
                      sl_d    = '0;
                      slope_d = '0;
                      if (meas >= {1'b0, se_q, 2'b00}) begin
                        // soak with no length ends at once
                        o_sms_d = '0;
                        stage_d = rpss_pkg::STG_RAMP;
                        if (rrs_q != '0) begin
                          op_d  = rpss_pkg::OP_SLOPE;
                          c_val = {{(AccW-24){diff_rp[9]}}, diff_rp, 14'b0};
                          den_d = {{(DenW-10){1'b0}}, rrs_q};
                          rnd_d = 1'b0;
                        end
                      end else begin
                        stage_d = rpss_pkg::STG_SOAK;
                      end
                    end else begin
                      stage_d = rpss_pkg::STG_SOAK;
                      sl_d    = ss_q;
                      op_d    = rpss_pkg::OP_SLOPE;
                      c_val   = {{(AccW-24){diff_sp[9]}}, diff_sp, 14'b0};
                      den_d   = {{(DenW-10){1'b0}}, ss_q};
                      rnd_d   = 1'b0;
                    end
                  end else if ((setp_q < {1'b0, pt_q}) && (meas >= base_q) && due) begin
                    pclk_d = pclk_new;
                    pvld_d = 1'b1;
                    last_d = now;
                    op_d   = rpss_pkg::OP_PRE;
                    a_mag  = now - pclk_new;
                    c_val  = {{(AccW-34){1'b0}}, base_k, 12'b0};
                    den_d  = rpss_pkg::MsQ14Den;
                    rnd_d  = 1'b1;
                  end
                end
                rpss_pkg::STG_SOAK: begin
                  if ((sl_q == '0) && (meas >= {1'b0, se_q, 2'b00})) begin
                    o_fin_d  = 1'b1;
                    o_sms_d  = now - sstart_q;
                    sstart_d = now;
                    stage_d  = rpss_pkg::STG_RAMP;
                    last_d   = now;
                    if (rrs_q == '0) begin
                      slope_d = '0;
                    end else begin
                      op_d  = rpss_pkg::OP_SLOPE;
                      c_val = {{(AccW-24){diff_rp[9]}}, diff_rp, 14'b0};
                      den_d = {{(DenW-10){1'b0}}, rrs_q};
                      rnd_d = 1'b0;
                    end
                  end else if (due) begin
                    last_d = now;
                    op_d   = rpss_pkg::OP_SOAK;
                    a_mag  = {21'b0, a_soak_mag};
                    b_neg  = a_soak[10];
                    c_val  = {{(AccW-23){1'b0}}, pt_q, 14'b0};
                    den_d  = rpss_pkg::Q14Den;
                    rnd_d  = 1'b1;
                    if (sl_q != '0) begin
                      sl_d = sl_q - 1'b1;
                    end
                  end
                end
                rpss_pkg::STG_RAMP: begin
                  if (meas >= {1'b0, pk_q, 2'b00}) begin
                    o_fin_d  = 1'b1;
                    o_sms_d  = now - sstart_q;
                    sstart_d = now;
                    stage_d  = rpss_pkg::STG_HOLD;
                    sl_d     = rhs_q;
                    slope_d  = '0;
                    setp_d   = {1'b0, pk_q};
                    last_d   = now;
                  end else if ((setp_q < {1'b0, pk_q}) && due) begin
                    last_d = now;
                    op_d   = rpss_pkg::OP_RAMP;
                    a_mag  = now - sstart_q;
                    c_val  = {{(AccW-33){1'b0}}, se_k, 14'b0};
                    den_d  = rpss_pkg::MsQ14Den;
                    rnd_d  = 1'b1;
                  end
                end
                rpss_pkg::STG_HOLD: begin
                  if (sl_q == '0) begin
                    o_fin_d  = 1'b1;
                    o_sms_d  = now - sstart_q;
                    sstart_d = now;
                    stage_d  = rpss_pkg::STG_COOL;
                    slope_d  = {4'b0, crq_q, 10'b0};
                    last_d   = '0;
                    base_d   = meas;
                  end else if (due) begin
                    sl_d   = sl_q - 1'b1;
                    last_d = now;
                  end
                end
                rpss_pkg::STG_COOL: begin
                  if (meas <= rpss_pkg::CoolEndQ2) begin
                    o_fin_d  = 1'b1;
                    o_sms_d  = now - sstart_q;
                    sstart_d = now;
                    o_done_d = 1'b1;
                    o_rms_d  = now - rstart_q;
                    setp_d   = rpss_pkg::TempDone;
                    stage_d  = rpss_pkg::STG_DONE;
                  end else if (due) begin
                    last_d = now;
                    op_d   = rpss_pkg::OP_COOL;
                    a_mag  = now - sstart_q;
                    den_d  = rpss_pkg::MsQ14Den;
                    rnd_d  = 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
            default: begin
            end
          endcase
          o_stage_d = stage_d;
          if (op_d == rpss_pkg::OP_NONE) begin
            ov_d    = 1'b1;
            o_tgt_d = setp_d;
          end else begin
            mul_go = 1'b1;
            st_d   = SEQ_MUL;
          end
        end
      end
      SEQ_MUL: begin
        if (mul_done) begin
          div_go = 1'b1;
          neg_d  = prod[AccW-1];
          st_d   = SEQ_DIV;
        end
      end
      SEQ_DIV: begin
        if (div_done) begin
          unique case (op_q)
            rpss_pkg::OP_SLOPE: slope_d = slope_fin;
            rpss_pkg::OP_COOL:  setp_d  = cool_t;
            default: begin
              if (neg_q) begin
                setp_d = '0;
              end else begin
                setp_d = (sat_q > lim) ? lim : sat_q;
              end
            end
          endcase
          if (op_q == rpss_pkg::OP_SLOPE) begin
            o_tgt_d = setp_q;
          end else if (op_q == rpss_pkg::OP_COOL) begin
            o_tgt_d = cool_t;
          end else begin
            o_tgt_d = neg_q ? 10'd0 : ((sat_q > lim) ? lim : sat_q);
          end
          ov_d = 1'b1;
          st_d = SEQ_IDLE;
        end
      end
      default: begin
        st_d = SEQ_IDLE;
      end
    endcase
  end

  // sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SEQ_IDLE;
      stage_q   <= rpss_pkg::STG_IDLE;
      op_q      <= rpss_pkg::OP_NONE;
      sstart_q  <= '0;
      rstart_q  <= '0;
      pclk_q    <= '0;
      pvld_q    <= 1'b0;
      last_q    <= '0;
      base_q    <= '0;
      setp_q    <= '0;
      sl_q      <= '0;
      slope_q   <= '0;
      den_q     <= '0;
      rnd_q     <= 1'b0;
      neg_q     <= 1'b0;
      ov_q      <= 1'b0;
      o_tgt_q   <= '0;
      o_stage_q <= rpss_pkg::STG_IDLE;
      o_done_q  <= 1'b0;
      o_fin_q   <= 1'b0;
      o_sms_q   <= '0;
      o_rms_q   <= '0;
    end else begin
      st_q      <= st_d;
      stage_q   <= stage_d;
      op_q      <= op_d;
      sstart_q  <= sstart_d;
      rstart_q  <= rstart_d;
      pclk_q    <= pclk_d;
      pvld_q    <= pvld_d;
      last_q    <= last_d;
      base_q    <= base_d;
      setp_q    <= setp_d;
      sl_q      <= sl_d;
      slope_q   <= slope_d;
      den_q     <= den_d;
      rnd_q     <= rnd_d;
      neg_q     <= neg_d;
      ov_q      <= ov_d;
      o_tgt_q   <= o_tgt_d;
      o_stage_q <= o_stage_d;
      o_done_q  <= o_done_d;
      o_fin_q   <= o_fin_d;
      o_sms_q   <= o_sms_d;
      o_rms_q   <= o_rms_d;
    end
  end

  // profile register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q  <= 9'd150;
      prs_q <= 10'd90;
      ss_q  <= 10'd90;
      se_q  <= 9'd180;
      pk_q  <= 9'd240;
      rrs_q <= 10'd60;
      rhs_q <= 10'd30;
      crq_q <= 10'd48;
    end else if (cfg_we_i) begin
      unique case (rpss_pkg::cfg_idx_e'(cfg_idx_i))
        rpss_pkg::CFG_PREHEAT_TEMP: pt_q  <= cfg_data_i[8:0];
        rpss_pkg::CFG_PREHEAT_SECS: prs_q <= cfg_data_i;
        rpss_pkg::CFG_SOAK_SECS:    ss_q  <= cfg_data_i;
        rpss_pkg::CFG_SOAK_TEMP:    se_q  <= cfg_data_i[8:0];
        rpss_pkg::CFG_PEAK_TEMP:    pk_q  <= cfg_data_i[8:0];
        rpss_pkg::CFG_RAMP_SECS:    rrs_q <= cfg_data_i;
        rpss_pkg::CFG_HOLD_SECS:    rhs_q <= cfg_data_i;
        rpss_pkg::CFG_COOL_RATE:    crq_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // serial arithmetic units
  rpss_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (a_mag),
    .b_i     (b_in),
    .c_i     (c_val),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  rpss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .q_o     (quo)
  );

  assign out_valid_o        = ov_q;
  assign target_temp_o      = o_tgt_q;
  assign stage_o            = o_stage_q;
  assign run_complete_o     = o_done_q;
  assign stage_finished_o   = o_fin_q;
  assign stage_elapsed_ms_o = o_sms_q;
  assign run_elapsed_ms_o   = o_rms_q;

`ifndef NO_ASSERTIONS
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("command taken while a result beat is pending");

  a_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_complete_o) |-> (stage_finished_o && (stage_o == rpss_pkg::STG_DONE)))
    else $error("run completion without stage end");

  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (st_q == SEQ_MUL))
    else $error("multiplier finished outside multiply phase");

  a_div_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == SEQ_DIV))
    else $error("divider finished outside divide phase");
`endif

endmodule
`default_nettype wire

// ----- src/rpss_mul.sv -----
// rpss_mul: bit-serial shift-add multiplier, acc = c + a * b, one bit of a per cycle
// depends on rpss_pkg for widths and step count
`default_nettype none
module rpss_mul (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [31:0]              a_i,
  input  wire logic [rpss_pkg::AccW-1:0] b_i,
  input  wire logic [rpss_pkg::AccW-1:0] c_i,
  output logic                          done_o,
  output logic [rpss_pkg::AccW-1:0]     p_o
);

  localparam logic [rpss_pkg::CntW-1:0] LastStep = rpss_pkg::CntW'(rpss_pkg::MulSteps - 1);

  logic                        busy_q;
  logic                        done_q;
  logic [rpss_pkg::CntW-1:0]   cnt_q;
  logic [31:0]                 a_q;
  logic [rpss_pkg::AccW-1:0]   b_q;
  logic [rpss_pkg::AccW-1:0]   acc_q;

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift and accumulate
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= c_i;
    end else if (busy_q) begin
      if (a_q[0]) begin
        acc_q <= acc_q + b_q;
      end
      a_q <= a_q >> 1;
      b_q <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

// ----- src/rpss_div.sv -----
// rpss_div: restoring divider, one quotient bit per cycle on unsigned magnitudes
// depends on rpss_pkg for widths and step count
`default_nettype none
module rpss_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [rpss_pkg::AccW-1:0] num_i,
  input  wire logic [rpss_pkg::DenW-1:0] den_i,
  output logic                          done_o,
  output logic [rpss_pkg::AccW-1:0]     q_o
);

  localparam logic [rpss_pkg::CntW-1:0] LastStep = rpss_pkg::CntW'(rpss_pkg::DivSteps - 1);

  logic                        busy_q;
  logic                        done_q;
  logic [rpss_pkg::CntW-1:0]   cnt_q;
  logic [rpss_pkg::AccW-1:0]   n_q;
  logic [rpss_pkg::DenW-1:0]   den_q;
  logic [rpss_pkg::DenW:0]     rem_q;
  logic [rpss_pkg::DenW:0]     rem_sh;
  logic                        ge;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem_q[rpss_pkg::DenW-1:0], n_q[rpss_pkg::AccW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out on top, quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[rpss_pkg::AccW-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

  assign done_o = done_q;
  assign q_o    = n_q;

endmodule
`default_nettype wire
